// ===== hw/rtl/rcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types and constants of the return covariance block.
// ----------------------------------------------------------------------------
package rcm_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RET_INIT,
		ST_RET_P0,
		ST_RET_P1,
		ST_RET_DIVW,
		ST_RET_WR,
		ST_COV_INIT,
		ST_COV_RUN,
		ST_COV_DRAIN,
		ST_COV_MULSET,
		ST_COV_MUL,
		ST_COV_DIV,
		ST_COV_DIVW,
		ST_COV_OUT
	} rcm_state_t;

	localparam int RET_W     = 32;
	localparam int RET_FRAC  = 28;
	localparam int PRICE_W   = 32;
	localparam int COV_W     = 64;
	localparam int DIVISOR_W = 32;

	localparam logic [1:0] REG_ASSET_COUNT = 2'd0;
	localparam logic [1:0] REG_DATE_COUNT  = 2'd1;

endpackage

// ===== hw/rtl/return_covariance_matrix.sv =====
// ----------------------------------------------------------------------------
// return_covariance_matrix
// Sample covariance of simple price returns, lower triangle out row by row.
// ----------------------------------------------------------------------------
// Prices are taken one beat per cycle into a price memory. The beat with
// tlast set starts the computation and input stays stalled until the
// triangle has gone out. Returns are formed one date at a time through a
// shared bit-serial divider of DW = 66 + 2*log2(MAX_DATES) bits. Each pair
// then streams both return rows of n = date_count - 1 returns from a
// dual-read return memory, forms the product of the row sums bit-serially
// and divides by n*(n-1) in the same divider. Each output beat is held
// until the sink takes it. The price memory is not cleared by reset.
module return_covariance_matrix #(
	parameter int MAX_ASSETS = 8,
	parameter int MAX_DATES  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// price beats
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // asset_index[2:0], date_index[10:3], price[42:11]
	input  logic        s_axis_tlast,  // load_done
	// covariance beats
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // row[2:0], col[5:3], covariance_value[69:6]
	output logic        m_axis_tuser,  // status
	output logic        m_axis_tlast   // last_entry
);
	import rcm_pkg::*;

	localparam int AIW    = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
	localparam int DATE_W = $clog2(MAX_DATES);
	localparam int AW     = AIW + DATE_W;
	localparam int DEPTH  = 2 ** AW;
	localparam int PROD_W = 2 * RET_W;
	localparam int NPR_W  = PROD_W + DATE_W + 1;
	localparam int ACC_W  = PROD_W + 2 * DATE_W + 1;
	localparam int SUM_W  = RET_W + DATE_W;
	localparam int SS_W   = 2 * SUM_W;
	localparam int NUM_W  = SS_W + 2;
	localparam int DW     = NUM_W;
	localparam int MCW    = $clog2(SUM_W + 1);
	localparam int A_RST  = (4 > MAX_ASSETS) ? MAX_ASSETS : 4;
	localparam int D_RST  = (256 > MAX_DATES) ? MAX_DATES : 256;

	rcm_state_t state_q, state_d;

	logic [3:0]        asset_count_q;
	logic [8:0]        date_count_q;
	logic [3:0]        acnt_v;
	logic [8:0]        dcnt_v;

	logic [PRICE_W-1:0] price_mem [DEPTH];
	logic [RET_W-1:0]   ret_mem   [DEPTH];

	logic [2:0]         in_asset;
	logic [7:0]         in_date;
	logic [PRICE_W-1:0] in_price;
	logic               in_hit;
	logic               in_fire;
	logic [AW-1:0]      in_addr;

	logic [AW-1:0]      price_raddr;
	logic [PRICE_W-1:0] price_rdata;
	logic               ret_we;
	logic [AW-1:0]      ret_waddr;
	logic [RET_W-1:0]   ret_wdata;
	logic [AW-1:0]      ret_raddr_a;
	logic [AW-1:0]      ret_raddr_b;
	logic signed [RET_W-1:0] ret_ra;
	logic signed [RET_W-1:0] ret_rb;

	logic               zero_seen_q;
	logic [DATE_W-1:0]  n_q;
	logic [2*DATE_W-1:0] nn1_q;
	logic [AIW-1:0]     a_q;
	logic [AIW-1:0]     b_q;
	logic [DATE_W-1:0]  t_q;
	logic [PRICE_W-1:0] prev_q;
	logic               zret_q;
	logic               neg_q;
	logic [PRICE_W-1:0] diff;
	logic [RET_W-1:0]   ret_val;

	logic               v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [NPR_W-1:0]  nprod_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  sa_q, sb_q;
	logic [SS_W-1:0]    ms_a_q, ss_q;
	logic [SUM_W-1:0]   ms_b_q;
	logic [MCW-1:0]     mcnt_q;
	logic               ss_neg_q;
	logic               num_neg_q;
	logic signed [NUM_W-1:0] num;
	logic signed [NUM_W-1:0] ssv;
	logic [SUM_W-1:0]   sa_mag, sb_mag;
	logic [COV_W-1:0]   cov_val;

	logic               div_start, div_busy, div_done;
	logic [DW-1:0]      div_dividend, div_quo;
	logic [DIVISOR_W-1:0] div_divisor;

	logic               cov_issue;
	logic               last_pair;
	logic               last_date;
	logic               last_asset;

	logic [2:0]         out_row_q, out_col_q;
	logic [COV_W-1:0]   out_cov_q;
	logic               out_status_q, out_last_q;

	// configuration
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'(date_count_q) : 32'(asset_count_q);

	always_comb begin
		acnt_v = pwdata[3:0];
		if (acnt_v < 4'd1)
			acnt_v = 4'd1;
		if (int'(acnt_v) > MAX_ASSETS)
			acnt_v = 4'(MAX_ASSETS);
		dcnt_v = pwdata[8:0];
		if (dcnt_v < 9'd3)
			dcnt_v = 9'd3;
		if (int'(dcnt_v) > MAX_DATES)
			dcnt_v = 9'(MAX_DATES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asset_count_q <= 4'(A_RST);
			date_count_q  <= 9'(D_RST);
		end else if (psel && penable && pwrite) begin
			if ({1'b0, paddr[2]} == REG_ASSET_COUNT)
				asset_count_q <= acnt_v;
			else if ({1'b0, paddr[2]} == REG_DATE_COUNT)
				date_count_q <= dcnt_v;
		end
	end

	// input beat
	assign in_asset = s_axis_tdata[2:0];
	assign in_date  = s_axis_tdata[10:3];
	assign in_price = s_axis_tdata[42:11];
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign in_hit   = (int'(in_asset) < MAX_ASSETS) && (int'(in_date) < MAX_DATES);
	assign in_addr  = {AIW'(in_asset), DATE_W'(in_date)};

	// memories
	always_ff @(posedge clk) begin
		if (in_fire && in_hit)
			price_mem[in_addr] <= in_price;
		price_rdata <= price_mem[price_raddr];
	end

	always_ff @(posedge clk) begin
		if (ret_we)
			ret_mem[ret_waddr] <= ret_wdata;
		ret_ra <= ret_mem[ret_raddr_a];
		ret_rb <= ret_mem[ret_raddr_b];
	end

	rcm_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// return and covariance arithmetic
	always_comb begin
		diff = (price_rdata >= prev_q) ? price_rdata - prev_q : prev_q - price_rdata;
		if (zret_q)
			ret_val = '0;
		else if (neg_q)
			ret_val = RET_W'(-div_quo[RET_W-1:0]);
		else if (|div_quo[DW-1:RET_W-1])
			ret_val = {1'b0, {(RET_W-1){1'b1}}};
		else
			ret_val = div_quo[RET_W-1:0];

		sa_mag = sa_q[SUM_W-1] ? SUM_W'(-sa_q) : SUM_W'(sa_q);
		sb_mag = sb_q[SUM_W-1] ? SUM_W'(-sb_q) : SUM_W'(sb_q);
		ssv    = ss_neg_q ? -$signed(NUM_W'(ss_q)) : $signed(NUM_W'(ss_q));
		num    = NUM_W'(acc_q) - ssv;

		if (!num_neg_q) begin
			if ((|div_quo[DW-1:COV_W]) || div_quo[COV_W-1])
				cov_val = {1'b0, {(COV_W-1){1'b1}}};
			else
				cov_val = div_quo[COV_W-1:0];
		end else begin
			if ((|div_quo[DW-1:COV_W]) ||
			    (div_quo[COV_W-1] && (|div_quo[COV_W-2:0])))
				cov_val = {1'b1, {(COV_W-1){1'b0}}};
			else
				cov_val = COV_W'(-div_quo[COV_W-1:0]);
		end
	end

	assign last_date  = (t_q + 1'b1 == n_q);
	assign last_asset = (4'(a_q) + 4'd1 == asset_count_q);
	assign last_pair  = (b_q == a_q) && last_asset;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (in_fire && s_axis_tlast) state_d = ST_RET_INIT;
			ST_RET_INIT:   state_d = ST_RET_P0;
			ST_RET_P0:     state_d = ST_RET_P1;
			ST_RET_P1:     state_d = (prev_q == '0) ? ST_RET_WR : ST_RET_DIVW;
			ST_RET_DIVW:   if (div_done) state_d = ST_RET_WR;
			ST_RET_WR: begin
				if (!last_date)
					state_d = ST_RET_P1;
				else if (last_asset)
					state_d = ST_COV_INIT;
				else
					state_d = ST_RET_INIT;
			end
			ST_COV_INIT:   state_d = ST_COV_RUN;
			ST_COV_RUN:    if (last_date) state_d = ST_COV_DRAIN;
			ST_COV_DRAIN:  if (!v_s1 && !v_s2 && !v_s3) state_d = ST_COV_MULSET;
			ST_COV_MULSET: state_d = ST_COV_MUL;
			ST_COV_MUL:    if (mcnt_q == MCW'(SUM_W - 1)) state_d = ST_COV_DIV;
			ST_COV_DIV:    state_d = ST_COV_DIVW;
			ST_COV_DIVW:   if (div_done) state_d = ST_COV_OUT;
			ST_COV_OUT: begin
				if (m_axis_tready)
					state_d = last_pair ? ST_IDLE : ST_COV_INIT;
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		price_raddr   = {a_q, DATE_W'(t_q + 1'b1)};
		ret_we        = 1'b0;
		ret_waddr     = {a_q, t_q};
		ret_wdata     = ret_val;
		ret_raddr_a   = {a_q, t_q};
		ret_raddr_b   = {b_q, t_q};
		cov_issue     = 1'b0;
		div_start     = 1'b0;
		div_dividend  = DW'({diff, {RET_FRAC{1'b0}}});
		div_divisor   = prev_q;
		case (state_q)
			ST_IDLE:     s_axis_tready = 1'b1;
			ST_RET_INIT: price_raddr = {a_q, DATE_W'(0)};
			ST_RET_P0:   price_raddr = {a_q, DATE_W'(t_q + 1'b1)};
			ST_RET_P1:   div_start = (prev_q != '0);
			ST_RET_WR: begin
				ret_we      = 1'b1;
				price_raddr = {a_q, DATE_W'(t_q + 2'd2)};
			end
			ST_COV_RUN:  cov_issue = 1'b1;
			ST_COV_DIV: begin
				div_start    = 1'b1;
				div_dividend = num[NUM_W-1] ? DW'(-num) : DW'(num);
				div_divisor  = DIVISOR_W'(nn1_q);
			end
			ST_COV_OUT:  m_axis_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			zero_seen_q <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			t_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= cov_issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			if (in_fire && in_hit && (in_price == '0))
				zero_seen_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					a_q <= '0;
					t_q <= '0;
				end
				ST_RET_INIT: t_q <= '0;
				ST_RET_P1:   if (prev_q == '0) zero_seen_q <= 1'b1;
				ST_RET_WR: begin
					if (!last_date) begin
						t_q <= t_q + 1'b1;
					end else if (last_asset) begin
						a_q <= '0;
						b_q <= '0;
					end else begin
						a_q <= a_q + 1'b1;
					end
				end
				ST_COV_INIT: t_q <= '0;
				ST_COV_RUN:  t_q <= t_q + 1'b1;
				ST_COV_OUT: begin
					if (m_axis_tready) begin
						if (last_pair) begin
							zero_seen_q <= 1'b0;
						end else if (b_q == a_q) begin
							a_q <= a_q + 1'b1;
							b_q <= '0;
						end else begin
							b_q <= b_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire && s_axis_tlast) begin
			n_q   <= DATE_W'(date_count_q - 9'd1);
			nn1_q <= (2*DATE_W)'(DATE_W'(date_count_q - 9'd1) *
			                     DATE_W'(date_count_q - 9'd2));
		end
		if (state_q == ST_RET_P0)
			prev_q <= price_rdata;
		if (state_q == ST_RET_P1) begin
			zret_q <= (prev_q == '0);
			neg_q  <= (price_rdata < prev_q);
		end
		if (state_q == ST_RET_WR)
			prev_q <= price_rdata;

		if (state_q == ST_COV_INIT) begin
			acc_q <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
		end
		if (v_s1) begin
			prod_s2 <= ret_ra * ret_rb;
			sa_q    <= sa_q + SUM_W'(ret_ra);
			sb_q    <= sb_q + SUM_W'(ret_rb);
		end
		if (v_s2)
			nprod_s3 <= NPR_W'(prod_s2) * $signed({1'b0, n_q});
		if (v_s3)
			acc_q <= acc_q + ACC_W'(nprod_s3);

		if (state_q == ST_COV_MULSET) begin
			ms_a_q   <= SS_W'(sa_mag);
			ms_b_q   <= sb_mag;
			ss_q     <= '0;
			mcnt_q   <= '0;
			ss_neg_q <= sa_q[SUM_W-1] ^ sb_q[SUM_W-1];
		end
		if (state_q == ST_COV_MUL) begin
			if (ms_b_q[0])
				ss_q <= ss_q + ms_a_q;
			ms_a_q <= {ms_a_q[SS_W-2:0], 1'b0};
			ms_b_q <= {1'b0, ms_b_q[SUM_W-1:1]};
			mcnt_q <= mcnt_q + 1'b1;
		end
		if (state_q == ST_COV_DIV)
			num_neg_q <= num[NUM_W-1];
		if (state_q == ST_COV_DIVW && div_done) begin
			out_row_q    <= 3'(a_q);
			out_col_q    <= 3'(b_q);
			out_cov_q    <= zero_seen_q ? '0 : cov_val;
			out_status_q <= zero_seen_q;
			out_last_q   <= last_pair;
		end
	end

	assign m_axis_tdata = {2'b00, out_cov_q, out_col_q, out_row_q};
	assign m_axis_tuser = out_status_q;
	assign m_axis_tlast = out_last_q;

	a_col_le_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_col_q <= out_row_q))
		else $error("column above row");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while a result is pending");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
			(state_q == ST_IDLE && !zero_seen_q))
		else $error("triangle end did not return to idle");

endmodule

// ===== hw/rtl/rcm_div.sv =====
// ----------------------------------------------------------------------------
// rcm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcm_div #(
	parameter int DW = 82
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [DW-1:0]                        dividend,
	input  logic [rcm_pkg::DIVISOR_W-1:0]        divisor,
	output logic                                 busy,
	output logic                                 done,
	output logic [DW-1:0]                        quotient
);
	import rcm_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DW-1:0]     quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [DIVISOR_W:0]   trial;
	logic              step_bit;
	logic [DIVISOR_W-1:0] step_rem;

	always_comb begin
		trial    = {rem_q, quo_q[DW-1]};
		step_bit = (trial >= {1'b0, div_q});
		step_rem = step_bit ? DIVISOR_W'(trial - {1'b0, div_q}) : trial[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], step_bit};
			rem_q <= step_rem;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== dv/return_covariance_matrix_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// return_covariance_matrix_tb
// Self-checking bench for the return covariance block. Price beats are queued
// per frame and driven with random gaps. A predictor mirrors the price store
// and forms returns and Q7.56 covariances in 128-bit arithmetic for every
// frame end. Output beats are checked in order against the predicted triangle
// while the sink stalls at random, with one long hold-off.
// ----------------------------------------------------------------------------
module return_covariance_matrix_tb;
	import rcm_pkg::*;

	localparam int ASSETS = 8;
	localparam int DATES  = 256;
	localparam int FILL_DATES = 16;
	localparam int LIMIT  = 4000000;
	localparam logic [63:0] RET_SAT = 64'h7FFF_FFFF;

	typedef struct packed {
		logic [2:0]  asset;
		logic [7:0]  date;
		logic [31:0] price;
		logic        done;
	} price_beat_t;

	typedef struct packed {
		logic [2:0]  row;
		logic [2:0]  col;
		logic [63:0] cov;
		logic        status;
		logic        last;
	} cov_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // asset_index, date_index, price
	logic        s_axis_tlast;   // load_done
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;   // row, col, covariance_value
	logic        m_axis_tuser;   // status
	logic        m_axis_tlast;   // last_entry

	return_covariance_matrix dut (.*);

	price_beat_t beats[$];
	cov_beat_t   triangle[$];
	price_beat_t cur;

	logic [31:0]        prices[ASSETS][DATES];
	logic [31:0]        plan[ASSETS][DATES];
	logic signed [63:0] rets[ASSETS][DATES];
	logic signed [63:0] sums[ASSETS];
	logic signed [63:0] mean_ret[ASSETS];
	logic               zero_seen = 1'b0;
	int                 assets_cfg = 4;
	int                 dates_cfg = 256;

	int  mismatches = 0;
	int  idle_max = 7;
	int  stall_max = 7;
	int  gap;
	int  out_wait;
	int  hold_cnt;
	logic hold_go = 1'b0;
	logic hold_armed;
	longint cycles = 0;

	initial forever #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic signed [63:0] return_q28(input logic [31:0] p0, p1,
			inout logic err);
		logic [63:0] m;
		if (p0 == 0) begin
			err = 1'b1;
			return 0;
		end
		if (p1 >= p0) begin
			m = ({32'd0, 32'(p1 - p0)} << 28) / {32'd0, p0};
			if (m > RET_SAT)
				m = RET_SAT;
			return $signed(m);
		end
		m = ({32'd0, 32'(p0 - p1)} << 28) / {32'd0, p0};
		return -$signed(m);
	endfunction

	function automatic logic [63:0] covariance_q56(input int a, c, n);
		logic signed [127:0] acc, x, y, num, n_w;
		logic [127:0] mag;
		logic neg;
		acc = 0;
		n_w = n;
		for (int t = 0; t < n; t++) begin
			x = rets[a][t];
			y = rets[c][t];
			acc = acc + x * y;
		end
		x = sums[a];
		y = sums[c];
		num = acc * n_w - x * y;
		neg = num < 0;
		mag = neg ? -num : num;
		mag = mag / (n_w * (n_w - 1));
		if (!neg)
			return (mag > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : mag[63:0];
		if (mag > 128'h8000_0000_0000_0000)
			return 64'h8000_0000_0000_0000;
		return -mag[63:0];
	endfunction

	// store one price; on frame end predict the whole triangle
	task automatic absorb_price(input price_beat_t b);
		logic err;
		logic signed [63:0] s, r;
		int n;
		cov_beat_t e;
		prices[b.asset][b.date] = b.price;
		if (b.price == 0)
			zero_seen = 1'b1;
		if (!b.done)
			return;
		err = zero_seen;
		n = dates_cfg - 1;
		for (int a = 0; a < assets_cfg; a++) begin
			s = 0;
			for (int t = 0; t < n; t++) begin
				r = return_q28(prices[a][t], prices[a][t + 1], err);
				rets[a][t] = r;
				s = s + r;
			end
			sums[a] = s;
			mean_ret[a] = s / n;
		end
		for (int a = 0; a < assets_cfg; a++) begin
			for (int c = 0; c <= a; c++) begin
				e.row = 3'(a);
				e.col = 3'(c);
				e.cov = err ? 64'd0 : covariance_q56(a, c, n);
				e.status = err;
				e.last = (a + 1 == assets_cfg) && (c == a);
				triangle.push_back(e);
			end
		end
		zero_seen = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				absorb_price(cur);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap != 0) begin
					gap <= gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (beats.size() != 0) begin
					cur = beats.pop_front();
					s_axis_tdata <= {5'd0, cur.price, cur.date, cur.asset};
					s_axis_tlast <= cur.done;
					s_axis_tvalid <= 1'b1;
					gap <= $urandom_range(0, idle_max);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] want, got);
		$display("%0t %s: expected %h got %h", $time, what, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cov_beat_t e;
		int w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_wait <= 0;
		end else begin
			w = out_wait;
			if (m_axis_tvalid && m_axis_tready) begin
				if (triangle.size() == 0) begin
					report_mismatch("unexpected beat", 64'd0, m_axis_tdata[69:6]);
				end else begin
					e = triangle.pop_front();
					if (m_axis_tdata[2:0] != e.row)
						report_mismatch("row", 64'(e.row), 64'(m_axis_tdata[2:0]));
					if (m_axis_tdata[5:3] != e.col)
						report_mismatch("col", 64'(e.col), 64'(m_axis_tdata[5:3]));
					if (m_axis_tdata[69:6] != e.cov)
						report_mismatch("covariance", e.cov, m_axis_tdata[69:6]);
					if (m_axis_tuser != e.status)
						report_mismatch("status", 64'(e.status), 64'(m_axis_tuser));
					if (m_axis_tlast != e.last)
						report_mismatch("last", 64'(e.last), 64'(m_axis_tlast));
				end
				w = $urandom_range(0, stall_max);
			end else if (w != 0) begin
				w--;
			end
			out_wait <= w;
			m_axis_tready <= (w == 0) && (hold_cnt == 0);
		end
	end

	// long sink hold-off, counted here; it starts at the first result after arming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_armed <= 1'b0;
		end else if (hold_go) begin
			hold_armed <= 1'b1;
		end else if (hold_armed && m_axis_tvalid) begin
			hold_armed <= 1'b0;
			hold_cnt <= 500;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	task automatic queue_price(input int a, d, input logic [31:0] p, input logic done);
		price_beat_t b;
		b.asset = 3'(a);
		b.date = 8'(d);
		b.price = p;
		b.done = done;
		beats.push_back(b);
		plan[a][d] = p;
	endtask

	function automatic logic [31:0] walk(input logic [31:0] p);
		logic [31:0] d, q;
		d = $urandom_range(0, p >> 4);
		q = $urandom_range(0, 1) ? p + d : p - d;
		return (q == 0) ? 32'd1 : q;
	endfunction

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		int v;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_ASSET_COUNT) begin
			v = val & 32'hF;
			assets_cfg = (v < 1) ? 1 : (v > ASSETS) ? ASSETS : v;
		end else if (idx == REG_DATE_COUNT) begin
			v = val & 32'h1FF;
			dates_cfg = (v < 3) ? 3 : (v > DATES) ? DATES : v;
		end
	endtask

	task automatic wait_idle();
		while (beats.size() != 0 || s_axis_tvalid || triangle.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		int rand_items, frames, k, a, d, phase;
		logic [31:0] p;
		foreach (plan[i, j])
			plan[i][j] = 32'h0001_0000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every row over the widest date span used later
		cfg_write(REG_ASSET_COUNT, 8);
		cfg_write(REG_DATE_COUNT, FILL_DATES);
		for (a = 0; a < ASSETS; a++) begin
			p = $urandom_range(32'h0001_0000, 32'h0100_0000);
			for (d = 0; d < FILL_DATES; d++) begin
				p = walk(p);
				queue_price(a, d, p, a == ASSETS - 1 && d == FILL_DATES - 1);
			end
		end
		wait_idle();

		// directed
		cfg_write(REG_ASSET_COUNT, 2);
		cfg_write(REG_DATE_COUNT, 3);
		queue_price(0, 0, 32'd1, 0);            // return saturates high
		queue_price(0, 1, 32'hFFFF_FFFF, 0);
		queue_price(0, 2, 32'd1, 1);            // falls close to -1
		queue_price(1, 1, 32'd0, 1);            // zero divisor
		queue_price(1, 1, 32'h0002_0000, 1);    // error cleared
		queue_price(7, 200, 32'd0, 1);          // zero outside the used rows
		queue_price(7, 200, 32'h0001_0000, 0);
		queue_price(1, 0, 32'h8000_0000, 0);
		queue_price(1, 2, 32'h0000_FFFF, 1);
		wait_idle();

		// random frames over varying shapes
		rand_items = 0;
		phase = 0;
		while (rand_items < 130 || phase < 6) begin
			case (phase)
				0: begin cfg_write(REG_ASSET_COUNT, 0); cfg_write(REG_DATE_COUNT, 0); end
				1: begin cfg_write(REG_ASSET_COUNT, 15); cfg_write(REG_DATE_COUNT, 9); end
				2: begin cfg_write(REG_ASSET_COUNT, 2); cfg_write(REG_DATE_COUNT, FILL_DATES); end
				default: begin
					cfg_write(REG_ASSET_COUNT, $urandom_range(0, 15));
					cfg_write(REG_DATE_COUNT, $urandom_range(0, 14));
				end
			endcase
			idle_max = (phase % 3 == 2) ? 0 : 7;
			stall_max = (phase % 4 == 3) ? 0 : 7;
			if (phase == 1) begin
				@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			frames = (dates_cfg > 16) ? 1 : $urandom_range(2, 4);
			repeat (frames) begin
				k = $urandom_range(1, 12);
				for (int i = 0; i < k; i++) begin
					if ($urandom_range(0, 7) != 0) begin
						a = $urandom_range(0, assets_cfg - 1);
						d = $urandom_range(0, dates_cfg - 1);
					end else begin
						a = $urandom_range(0, ASSETS - 1);
						d = $urandom_range(0, DATES - 1);
					end
					case ($urandom_range(0, 31))
						0: p = 32'd0;
						1: p = 32'hFFFF_FFFF;
						2: p = 32'd1;
						3: p = $urandom;
						default: p = walk(plan[a][(d > 0) ? d - 1 : d + 1]);
					endcase
					queue_price(a, d, p, i == k - 1);
					rand_items++;
				end
			end
			wait_idle();
			phase++;
		end

		cfg_write(REG_ASSET_COUNT, 1);
		cfg_write(REG_DATE_COUNT, 3);
		queue_price(0, 1, walk(plan[0][1]), 1);
		wait_idle();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
